[rtl/pftc_pkg.sv]
// Shared types, constants and lookup tables for the perspective floor texel colour block.
// No dependencies; pftc_cfg, pftc_div, pftc_rot and the top module import this package.
package pftc_pkg;

    // Geometry and fixed-point constants
    localparam int FLOOR_FIRST_ROW = 14;
    localparam int SHADE_COUNT     = 34;
    localparam int RECIP_SHIFT     = 16;
    localparam int TRIG_FRAC       = 14;

    typedef logic signed [15:0] trig_t;
    typedef logic signed [7:0]  persp_coord_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FLOOR_ANGLE = 2'd0,
        REG_SCROLL_X    = 2'd1,
        REG_SCROLL_Z    = 2'd2
    } cfg_index_t;

    // Settings the colour stages read
    typedef struct packed {
        trig_t       sin_val;
        trig_t       cos_val;
        logic [5:0]  scroll_x;
        logic [5:0]  scroll_z;
    } cfg_state_t;

    // Perspective position handed from the divide stages to the rotate stages
    typedef struct packed {
        logic          on_floor;
        persp_coord_t  sx;
        persp_coord_t  sy;
        logic [5:0]    row;
    } persp_t;

    // First quadrant of sine, Q2.14
    localparam logic [14:0] QUARTER_SINE [0:64] = '{
        15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,
        15'd2801,  15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,
        15'd5520,  15'd5897,  15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,
        15'd8076,  15'd8423,  15'd8765,  15'd9102,  15'd9434,  15'd9760,  15'd10080,
        15'd10394, 15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
        15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623, 15'd13842,
        15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978, 15'd15137,
        15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
        15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364,
        15'd16379, 15'd16384
    };

    // floor(65536 / row); rows above the floor never use their entry
    localparam logic [12:0] ROW_RECIP [0:63] = '{
        13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,
        13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd4681, 13'd4369,
        13'd4096, 13'd3855, 13'd3640, 13'd3449, 13'd3276, 13'd3120, 13'd2978, 13'd2849,
        13'd2730, 13'd2621, 13'd2520, 13'd2427, 13'd2340, 13'd2259, 13'd2184, 13'd2114,
        13'd2048, 13'd1985, 13'd1927, 13'd1872, 13'd1820, 13'd1771, 13'd1724, 13'd1680,
        13'd1638, 13'd1598, 13'd1560, 13'd1524, 13'd1489, 13'd1456, 13'd1424, 13'd1394,
        13'd1365, 13'd1337, 13'd1310, 13'd1285, 13'd1260, 13'd1236, 13'd1213, 13'd1191,
        13'd1170, 13'd1149, 13'd1129, 13'd1110, 13'd1092, 13'd1074, 13'd1057, 13'd1040
    };

    // Shade per floor row, counted from the first floor row
    localparam logic [2:0] ROW_SHADE [0:SHADE_COUNT-1] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6
    };

    // Colour per tile (dark, light) and shade
    localparam logic [3:0] TILE_PALETTE [0:1][0:7] = '{
        '{4'd0, 4'd0, 4'd2, 4'd2, 4'd2, 4'd6, 4'd6, 4'd6},
        '{4'd2, 4'd2, 4'd6, 4'd6, 4'd7, 4'd7, 4'd15, 4'd15}
    };

    // Sine of a 256-step angle, Q2.14, folded from the quarter table
    function automatic trig_t sine_q14(input logic [7:0] angle);
        logic [6:0]  idx;
        logic [14:0] mag;
        idx = angle[6] ? 7'(7'd64 - {1'b0, angle[5:0]}) : {1'b0, angle[5:0]};
        mag = QUARTER_SINE[idx];
        return angle[7] ? trig_t'(-$signed({1'b0, mag})) : trig_t'({1'b0, mag});
    endfunction

endpackage

[rtl/pftc_pix_if.sv]
// Pixel request channel: valid/ready handshake carrying a screen column and row.
// No dependencies.
interface pftc_pix_if;
    logic       valid;
    logic       ready;
    logic [4:0] column;
    logic [5:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

[rtl/pftc_tex_if.sv]
// Texel result channel: valid/ready handshake carrying colour, floor coordinates and tile.
// No dependencies.
interface pftc_tex_if;
    logic       valid;
    logic       ready;
    logic [3:0] pixel_color;
    logic [5:0] texel_x;
    logic [5:0] texel_z;
    logic       near_tile;

    modport source (output valid, output pixel_color, output texel_x, output texel_z,
                    output near_tile, input ready);
    modport sink   (input valid, input pixel_color, input texel_x, input texel_z,
                    input near_tile, output ready);
endinterface

[rtl/pftc_cfg.sv]
// Configuration registers: rotation kept as sine/cosine pair, plus the two scroll offsets.
// Depends on pftc_pkg.
module pftc_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_wdata,
    output pftc_pkg::cfg_state_t cfg_state
);
    import pftc_pkg::*;

    trig_t      sin_reg;
    trig_t      cos_reg;
    logic [5:0] scroll_x_reg;
    logic [5:0] scroll_z_reg;

    // Angle writes go straight to the sine/cosine pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_reg      <= sine_q14(8'd0);
            cos_reg      <= sine_q14(8'd64);
            scroll_x_reg <= 6'd8;
            scroll_z_reg <= 6'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_FLOOR_ANGLE:
                begin
                    sin_reg <= sine_q14(cfg_wdata);
                    cos_reg <= sine_q14(8'(cfg_wdata + 8'd64));
                end
                REG_SCROLL_X: scroll_x_reg <= cfg_wdata[5:0];
                REG_SCROLL_Z: scroll_z_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    assign cfg_state.sin_val  = sin_reg;
    assign cfg_state.cos_val  = cos_reg;
    assign cfg_state.scroll_x = scroll_x_reg;
    assign cfg_state.scroll_z = scroll_z_reg;

endmodule

[rtl/pftc_div.sv]
// Perspective divide: three pipeline stages giving floor((num)/row) for both screen axes.
// Reciprocal multiply, then one remainder correction. Depends on pftc_pkg and pftc_pix_if.
module pftc_div #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    pftc_pix_if.sink         pix,
    output logic             persp_valid,
    input  logic             persp_ready,
    output pftc_pkg::persp_t persp
);
    import pftc_pkg::*;

    localparam logic signed [12:0] NUM_X_BASE = 13'(25 * COLUMNS - 25);

    // Stage A: numerators split into sign and magnitude, reciprocal looked up
    logic        a_valid_reg;
    logic        a_floor_reg;
    logic [10:0] a_mag_x_reg;
    logic [10:0] a_mag_y_reg;
    logic        a_neg_x_reg;
    logic        a_neg_y_reg;
    logic [12:0] a_recip_reg;
    logic [5:0]  a_row_reg;

    // Stage B: quotient estimates
    logic        b_valid_reg;
    logic        b_floor_reg;
    logic [10:0] b_mag_x_reg;
    logic [10:0] b_mag_y_reg;
    logic        b_neg_x_reg;
    logic        b_neg_y_reg;
    logic [6:0]  b_q_x_reg;
    logic [6:0]  b_q_y_reg;
    logic [5:0]  b_row_reg;

    // Stage C: floored signed quotients
    logic        c_valid_reg;
    persp_t      c_persp_reg;

    logic        ready_a;
    logic        ready_b;
    logic        ready_c;

    logic signed [12:0] num_x_next;
    logic signed [12:0] num_y_next;
    logic               floor_next;
    logic [23:0]        prod_x_next;
    logic [23:0]        prod_y_next;
    persp_coord_t       sx_next;
    persp_coord_t       sy_next;

    // Per-stage ready: a stage moves on when empty or when its successor moves
    assign ready_c   = !c_valid_reg || persp_ready;
    assign ready_b   = !b_valid_reg || ready_c;
    assign ready_a   = !a_valid_reg || ready_b;
    assign pix.ready = ready_a;

    // Numerators and the floor/on-screen test
    always_comb
    begin
        num_x_next = NUM_X_BASE - $signed({2'b00, 11'(pix.column) * 11'd50});
        num_y_next = 13'sd1600 - $signed({1'b0, 12'(pix.row) * 12'd50});
        floor_next = (pix.row >= 6'(FLOOR_FIRST_ROW)) && ({1'b0, pix.row} < 7'(ROWS))
                     && ({2'b00, pix.column} < 7'(COLUMNS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (ready_a)
            a_valid_reg <= pix.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid && ready_a)
        begin
            a_floor_reg <= floor_next;
            a_neg_x_reg <= num_x_next[12];
            a_neg_y_reg <= num_y_next[12];
            a_mag_x_reg <= 11'(num_x_next[12] ? -num_x_next : num_x_next);
            a_mag_y_reg <= 11'(num_y_next[12] ? -num_y_next : num_y_next);
            a_recip_reg <= ROW_RECIP[pix.row];
            a_row_reg   <= pix.row;
        end
    end

    // Quotient estimate: at most one below the true quotient
    assign prod_x_next = 24'(a_mag_x_reg) * 24'(a_recip_reg);
    assign prod_y_next = 24'(a_mag_y_reg) * 24'(a_recip_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (ready_b)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && ready_b)
        begin
            b_floor_reg <= a_floor_reg;
            b_mag_x_reg <= a_mag_x_reg;
            b_mag_y_reg <= a_mag_y_reg;
            b_neg_x_reg <= a_neg_x_reg;
            b_neg_y_reg <= a_neg_y_reg;
            b_q_x_reg   <= prod_x_next[RECIP_SHIFT+6:RECIP_SHIFT];
            b_q_y_reg   <= prod_y_next[RECIP_SHIFT+6:RECIP_SHIFT];
            b_row_reg   <= a_row_reg;
        end
    end

    // Remainder correction, then floor toward minus infinity for negative numerators
    function automatic persp_coord_t fix_quot(input logic [10:0] mag, input logic [6:0] q,
                                              input logic neg, input logic [5:0] d);
        logic [12:0] rem;
        logic        ge;
        logic        nz;
        logic [7:0]  q1;
        rem = 13'(mag) - 13'(13'(q) * 13'(d));
        ge  = rem[6:0] >= {1'b0, d};
        nz  = ge ? (rem[6:0] != {1'b0, d}) : (rem[6:0] != 7'd0);
        q1  = 8'(q) + 8'(ge);
        return neg ? persp_coord_t'(-$signed(8'(q1 + 8'(nz)))) : persp_coord_t'(q1);
    endfunction

    assign sx_next = fix_quot(b_mag_x_reg, b_q_x_reg, b_neg_x_reg, b_row_reg);
    assign sy_next = fix_quot(b_mag_y_reg, b_q_y_reg, b_neg_y_reg, b_row_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (ready_c)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg && ready_c)
        begin
            c_persp_reg.on_floor <= b_floor_reg;
            c_persp_reg.sx       <= sx_next;
            c_persp_reg.sy       <= sy_next;
            c_persp_reg.row      <= b_row_reg;
        end
    end

    assign persp_valid = c_valid_reg;
    assign persp       = c_persp_reg;

endmodule

[rtl/pftc_rot.sv]
// Rotate and colour: two pipeline stages, the four trig products and then scroll, tile, palette.
// Depends on pftc_pkg and pftc_tex_if.
module pftc_rot (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 persp_valid,
    output logic                 persp_ready,
    input  pftc_pkg::persp_t     persp,
    input  pftc_pkg::cfg_state_t cfg_state,
    pftc_tex_if.source           tex
);
    import pftc_pkg::*;

    // Stage D: low six bits of each floored product, and the row shade
    logic        d_valid_reg;
    logic        d_floor_reg;
    logic [5:0]  d_xc_reg;
    logic [5:0]  d_ys_reg;
    logic [5:0]  d_xs_reg;
    logic [5:0]  d_yc_reg;
    logic [2:0]  d_shade_reg;

    // Stage E: output register
    logic        e_valid_reg;
    logic [3:0]  e_color_reg;
    logic [5:0]  e_tex_x_reg;
    logic [5:0]  e_tex_z_reg;
    logic        e_tile_reg;

    logic        ready_d;
    logic        ready_e;

    logic signed [23:0] xc_next;
    logic signed [23:0] ys_next;
    logic signed [23:0] xs_next;
    logic signed [23:0] yc_next;
    logic [5:0]         shade_idx_next;
    logic [5:0]         tex_x_next;
    logic [5:0]         tex_z_next;
    logic               tile_next;

    assign ready_e     = !e_valid_reg || tex.ready;
    assign ready_d     = !d_valid_reg || ready_e;
    assign persp_ready = ready_d;

    // Products; an arithmetic shift by 14 is the floor, so keep bits 19..14
    always_comb
    begin
        xc_next = 24'(persp.sx) * 24'(cfg_state.cos_val);
        ys_next = 24'(persp.sy) * 24'(cfg_state.sin_val);
        xs_next = 24'(persp.sx) * 24'(cfg_state.sin_val);
        yc_next = 24'(persp.sy) * 24'(cfg_state.cos_val);
        shade_idx_next = 6'(persp.row - 6'(FLOOR_FIRST_ROW));
        if (shade_idx_next >= 6'(SHADE_COUNT))
            shade_idx_next = 6'(SHADE_COUNT - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (ready_d)
            d_valid_reg <= persp_valid;
    end

    always_ff @(posedge clk)
    begin
        if (persp_valid && ready_d)
        begin
            d_floor_reg <= persp.on_floor;
            d_xc_reg    <= xc_next[TRIG_FRAC+5:TRIG_FRAC];
            d_ys_reg    <= ys_next[TRIG_FRAC+5:TRIG_FRAC];
            d_xs_reg    <= xs_next[TRIG_FRAC+5:TRIG_FRAC];
            d_yc_reg    <= yc_next[TRIG_FRAC+5:TRIG_FRAC];
            d_shade_reg <= ROW_SHADE[shade_idx_next];
        end
    end

    // Sum modulo 64, scroll, mask to even coordinates, pick the tile
    always_comb
    begin
        tex_x_next = 6'(d_xc_reg - d_ys_reg + cfg_state.scroll_x) & 6'd62;
        tex_z_next = 6'(d_xs_reg + d_yc_reg + cfg_state.scroll_z) & 6'd62;
        tile_next  = tex_x_next[4] ^ tex_z_next[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (ready_e)
            e_valid_reg <= d_valid_reg;
    end

    // Pixels above the floor or off screen give all-zero fields
    always_ff @(posedge clk)
    begin
        if (d_valid_reg && ready_e)
        begin
            if (d_floor_reg)
            begin
                e_color_reg <= TILE_PALETTE[tile_next][d_shade_reg];
                e_tex_x_reg <= tex_x_next;
                e_tex_z_reg <= tex_z_next;
                e_tile_reg  <= tile_next;
            end
            else
            begin
                e_color_reg <= 4'd0;
                e_tex_x_reg <= 6'd0;
                e_tex_z_reg <= 6'd0;
                e_tile_reg  <= 1'b0;
            end
        end
    end

    assign tex.valid       = e_valid_reg;
    assign tex.pixel_color = e_color_reg;
    assign tex.texel_x     = e_tex_x_reg;
    assign tex.texel_z     = e_tex_z_reg;
    assign tex.near_tile   = e_tile_reg;

endmodule

[rtl/perspective_floor_texel_color_top.sv]
// Perspective floor texel colour: five-stage pipeline, divide (3 stages) then rotate/colour (2).
// Path: the pixel transaction loads stage A; the pixel then passes through stages B, C, D and
// the output register E, which offers the texel transaction.
// Throughput: one pixel per cycle; each stage holds under back-pressure and fills bubbles.
// Reset clears all stage valid bits; angle resets to 0 and both scroll offsets to 8.
// Depends on pftc_pkg, pftc_pix_if, pftc_tex_if, pftc_cfg, pftc_div and pftc_rot.
module perspective_floor_texel_color_top #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    pftc_pix_if.sink    pix,
    pftc_tex_if.source  tex
);
    import pftc_pkg::*;

    cfg_state_t cfg_state;
    persp_t     persp;
    logic       persp_valid;
    logic       persp_ready;

    // Configuration registers
    pftc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_state (cfg_state)
    );

    // Perspective divide
    pftc_div #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix         (pix),
        .persp_valid (persp_valid),
        .persp_ready (persp_ready),
        .persp       (persp)
    );

    // Rotation, scroll and palette
    pftc_rot u_rot (
        .clk         (clk),
        .rst_n       (rst_n),
        .persp_valid (persp_valid),
        .persp_ready (persp_ready),
        .persp       (persp),
        .cfg_state   (cfg_state),
        .tex         (tex)
    );

    // The pipeline only refuses a pixel when the output register is full
    a_stall_needs_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        !pix.ready |-> tex.valid)
        else $error("input stalled while output register empty");

    // Coordinates are masked to even values
    a_texel_even: assert property (@(posedge clk) disable iff (!rst_n)
        tex.valid |-> (tex.texel_x[0] == 1'b0) && (tex.texel_z[0] == 1'b0))
        else $error("odd texel coordinate");

    // Tile follows bit 4 of both coordinates
    a_tile_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        tex.valid |-> (tex.near_tile == (tex.texel_x[4] ^ tex.texel_z[4])))
        else $error("tile select disagrees with coordinates");

    // Divide stage output stalls only while the output register is full
    a_persp_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (persp_valid && !persp_ready) |-> tex.valid)
        else $error("divide output stalled with empty output register");

endmodule
